### rtl/core/mbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types, character codes and helper functions for the multipart body
// parser: result kinds, parse states, sequencer phases, ctrl/datapath bundles.
// ----------------------------------------------------------------------------
package mbp_pkg;

   localparam int BYTE_W             = 8;
   localparam int LEN_W              = 6;
   localparam int CSR_DATA_W         = 64;
   localparam int CSR_ADDR_W         = 6;
   localparam int REG_IDX_W          = 3;
   localparam int DEF_BOUNDARY_BYTES = 56;

   // register map, index = paddr[5:3]
   localparam logic [REG_IDX_W-1:0] REG_LENGTH    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BND_FIRST = 3'd1;

   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_HY    = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_HT    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

   // length of the withheld delimiter prefix to replay
   localparam logic [2:0] PFX_CR      = 3'd1;
   localparam logic [2:0] PFX_CRLF    = 3'd2;
   localparam logic [2:0] PFX_CRLF_HY = 3'd3;
   localparam logic [2:0] PFX_FULL    = 3'd4;

   typedef enum logic [3:0] {
      KIND_NAME       = 4'd0,
      KIND_VALUE      = 4'd1,
      KIND_DATA       = 4'd2,
      KIND_BODY_BEGIN = 4'd3,
      KIND_PART_BEGIN = 4'd4,
      KIND_HDRS_DONE  = 4'd5,
      KIND_PART_END   = 4'd6,
      KIND_BODY_END   = 4'd7,
      KIND_ERROR      = 4'd8
   } kind_type;

   typedef enum logic [4:0] {
      ST_PREAMBLE, ST_PRE_HY, ST_FIRST, ST_HF_START, ST_HF, ST_HV_START,
      ST_HV, ST_HV_CR, ST_HDONE, ST_DATA, ST_D_CR, ST_D_CRLF, ST_D_CRLF_HY,
      ST_D_BND, ST_BND_DONE, ST_BND_CR, ST_BND_HY, ST_EPILOGUE, ST_HALT
   } pstate_type;

   typedef enum logic [1:0] {
      PH_RUN,     // taking input bytes
      PH_PAIR,    // second event of a two-event byte
      PH_FLUSH,   // replaying withheld delimiter bytes
      PH_TAIL     // byte that broke the delimiter, as data
   } phase_type;

   typedef enum logic [2:0] {
      SRC_ZERO, SRC_REQ, SRC_HOLD, SRC_SEQ, SRC_CR
   } src_type;

   typedef enum logic [1:0] {
      MI_KEEP, MI_CLEAR, MI_INC
   } mi_op_type;

   typedef struct packed {
      logic is_cr;
      logic is_lf;
      logic is_hy;
      logic is_sp;
      logic is_ht;
      logic is_colon;
      logic is_token;
      logic mi_eq_len;
      logic mi_eq_len1;
      logic bnd_match;
      logic mi_last;
      logic flush_end;
      logic hold_cr;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic      emit;
      kind_type  kind;
      src_type   src;
      logic      last;
      mi_op_type mi_op;
      logic      capture;
      logic [2:0] pfx;
      logic      flush_step;
      logic      flush_rd;
   } cmd_type;

   function automatic logic is_token(input logic [BYTE_W-1:0] c);
      logic r;
      r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A);
      case (c)
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
         8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
         default: r = r;
      endcase
      return r;
   endfunction

   // CR LF - - : the fixed head of a delimiter
   function automatic logic [BYTE_W-1:0] seq_prefix(input logic [1:0] idx);
      logic [BYTE_W-1:0] r;
      unique case (idx)
         2'd0: r = CH_CR;
         2'd1: r = CH_LF;
         2'd2: r = CH_HY;
         2'd3: r = CH_HY;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/mbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_ctrl
// Parse state machine and result sequencer. Decides per byte which results
// go out and drives the datapath with one command bundle per cycle.
// ----------------------------------------------------------------------------
module mbp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_message_start,
   output logic                 req_stall,
   input  mbp_pkg::status_type  sts,
   output mbp_pkg::cmd_type     cmd
);
   import mbp_pkg::*;

   pstate_type parse_state_ff, parse_state_in;
   phase_type  phase_ff, phase_in;
   pstate_type st_eff;
   logic       accept;

   assign req_stall = !(phase_ff == PH_RUN && sts.out_free);
   assign accept    = req_valid && !req_stall;
   assign st_eff    = req_message_start ? ST_PREAMBLE : parse_state_ff;

   function automatic pstate_type field_next(input status_type s);
      pstate_type r;
      if (s.is_token)      r = ST_HF;
      else if (s.is_colon) r = ST_HV_START;
      else if (s.is_cr)    r = ST_HV_CR;
      else                 r = ST_HALT;
      return r;
   endfunction

   function automatic cmd_type put(input cmd_type c, input kind_type k,
                                   input src_type s, input logic l);
      cmd_type r;
      r      = c;
      r.emit = 1'b1;
      r.kind = k;
      r.src  = s;
      r.last = l;
      return r;
   endfunction

   // next state
   always_comb begin
      parse_state_in = parse_state_ff;
      phase_in       = phase_ff;
      unique case (phase_ff)
         PH_RUN: begin
            if (accept) begin
               parse_state_in = st_eff;
               unique case (st_eff)
                  ST_PREAMBLE:
                     if (sts.is_hy) parse_state_in = ST_PRE_HY;
                  ST_PRE_HY:
                     parse_state_in = sts.is_hy ? ST_FIRST : ST_PREAMBLE;
                  ST_FIRST: begin
                     if (sts.mi_eq_len) begin
                        if (!sts.is_cr) parse_state_in = ST_HALT;
                     end else if (sts.mi_eq_len1) begin
                        if (sts.is_lf) begin
                           parse_state_in = ST_HF_START;
                           phase_in       = PH_PAIR;
                        end else begin
                           parse_state_in = ST_HALT;
                        end
                     end else if (!sts.bnd_match) begin
                        parse_state_in = ST_HALT;
                     end
                  end
                  ST_HF_START:
                     parse_state_in = sts.is_cr ? ST_HDONE : field_next(sts);
                  ST_HF:
                     parse_state_in = field_next(sts);
                  ST_HV_START:
                     if (!sts.is_sp && !sts.is_ht)
                        parse_state_in = sts.is_cr ? ST_HV_CR : ST_HV;
                  ST_HV:
                     parse_state_in = sts.is_cr ? ST_HV_CR : ST_HV;
                  ST_HV_CR:
                     parse_state_in = sts.is_lf ? ST_HF_START : ST_HALT;
                  ST_HDONE:
                     parse_state_in = sts.is_lf ? ST_DATA : ST_HALT;
                  ST_DATA:
                     parse_state_in = sts.is_cr ? ST_D_CR : ST_DATA;
                  ST_D_CR: begin
                     if (sts.is_lf) begin
                        parse_state_in = ST_D_CRLF;
                     end else begin
                        parse_state_in = sts.is_cr ? ST_D_CR : ST_DATA;
                        phase_in       = sts.is_cr ? PH_RUN : PH_TAIL;
                     end
                  end
                  ST_D_CRLF: begin
                     if (sts.is_hy) begin
                        parse_state_in = ST_D_CRLF_HY;
                     end else begin
                        parse_state_in = sts.is_cr ? ST_D_CR : ST_DATA;
                        phase_in       = PH_FLUSH;
                     end
                  end
                  ST_D_CRLF_HY: begin
                     if (sts.is_hy) begin
                        parse_state_in = ST_D_BND;
                     end else begin
                        parse_state_in = sts.is_cr ? ST_D_CR : ST_DATA;
                        phase_in       = PH_FLUSH;
                     end
                  end
                  ST_D_BND: begin
                     if (sts.bnd_match) begin
                        parse_state_in = sts.mi_last ? ST_BND_DONE : ST_D_BND;
                     end else begin
                        parse_state_in = sts.is_cr ? ST_D_CR : ST_DATA;
                        phase_in       = PH_FLUSH;
                     end
                  end
                  ST_BND_DONE: begin
                     if (sts.is_cr)      parse_state_in = ST_BND_CR;
                     else if (sts.is_hy) parse_state_in = ST_BND_HY;
                     else                parse_state_in = ST_HALT;
                  end
                  ST_BND_CR: begin
                     if (sts.is_lf) begin
                        parse_state_in = ST_HF_START;
                        phase_in       = PH_PAIR;
                     end else begin
                        parse_state_in = ST_HALT;
                     end
                  end
                  ST_BND_HY: begin
                     if (sts.is_hy) begin
                        parse_state_in = ST_EPILOGUE;
                        phase_in       = PH_PAIR;
                     end else begin
                        parse_state_in = ST_HALT;
                     end
                  end
                  ST_EPILOGUE: parse_state_in = ST_EPILOGUE;
                  default:     parse_state_in = ST_HALT;
               endcase
            end
         end
         PH_PAIR, PH_TAIL: begin
            if (sts.out_free) phase_in = PH_RUN;
         end
         PH_FLUSH: begin
            if (sts.out_free && sts.flush_end)
               phase_in = sts.hold_cr ? PH_RUN : PH_TAIL;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.kind     = KIND_DATA;
      cmd.src      = SRC_ZERO;
      cmd.mi_op    = MI_KEEP;
      cmd.flush_rd = (phase_ff == PH_FLUSH);
      unique case (phase_ff)
         PH_RUN: begin
            if (accept) begin
               cmd.mi_op = req_message_start ? MI_CLEAR : MI_KEEP;
               unique case (st_eff)
                  ST_PRE_HY:
                     if (sts.is_hy) cmd.mi_op = MI_CLEAR;
                  ST_FIRST: begin
                     if (sts.mi_eq_len) begin
                        if (sts.is_cr) cmd.mi_op = MI_INC;
                        else           cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                     end else if (sts.mi_eq_len1) begin
                        if (sts.is_lf) begin
                           cmd       = put(cmd, KIND_BODY_BEGIN, SRC_ZERO, 1'b0);
                           cmd.mi_op = MI_CLEAR;
                        end else begin
                           cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                        end
                     end else if (sts.bnd_match) begin
                        cmd.mi_op = MI_INC;
                     end else begin
                        cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                     end
                  end
                  ST_HF_START, ST_HF: begin
                     // a CR at line start ends the header block, not the field
                     if (!(st_eff == ST_HF_START && sts.is_cr)) begin
                        if (sts.is_token)
                           cmd = put(cmd, KIND_NAME, SRC_REQ, 1'b1);
                        else if (!sts.is_colon && !sts.is_cr)
                           cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                     end
                  end
                  ST_HV_START:
                     if (!sts.is_sp && !sts.is_ht && !sts.is_cr)
                        cmd = put(cmd, KIND_VALUE, SRC_REQ, 1'b1);
                  ST_HV:
                     if (!sts.is_cr) cmd = put(cmd, KIND_VALUE, SRC_REQ, 1'b1);
                  ST_HV_CR:
                     if (!sts.is_lf) cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                  ST_HDONE: begin
                     if (sts.is_lf) cmd = put(cmd, KIND_HDRS_DONE, SRC_ZERO, 1'b1);
                     else           cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                  end
                  ST_DATA:
                     if (!sts.is_cr) cmd = put(cmd, KIND_DATA, SRC_REQ, 1'b1);
                  ST_D_CR: begin
                     if (!sts.is_lf) begin
                        cmd         = put(cmd, KIND_DATA, SRC_CR, sts.is_cr);
                        cmd.capture = 1'b1;
                        cmd.pfx     = PFX_CR;
                     end
                  end
                  ST_D_CRLF: begin
                     if (!sts.is_hy) begin
                        cmd         = put(cmd, KIND_DATA, SRC_CR, 1'b0);
                        cmd.capture = 1'b1;
                        cmd.pfx     = PFX_CRLF;
                     end
                  end
                  ST_D_CRLF_HY: begin
                     if (sts.is_hy) begin
                        cmd.mi_op = MI_CLEAR;
                     end else begin
                        cmd         = put(cmd, KIND_DATA, SRC_CR, 1'b0);
                        cmd.capture = 1'b1;
                        cmd.pfx     = PFX_CRLF_HY;
                     end
                  end
                  ST_D_BND: begin
                     if (sts.bnd_match) begin
                        cmd.mi_op = sts.mi_last ? MI_CLEAR : MI_INC;
                     end else begin
                        cmd         = put(cmd, KIND_DATA, SRC_CR, 1'b0);
                        cmd.capture = 1'b1;
                        cmd.pfx     = PFX_FULL;
                        cmd.mi_op   = MI_CLEAR;
                     end
                  end
                  ST_BND_DONE:
                     if (!sts.is_cr && !sts.is_hy)
                        cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                  ST_BND_CR: begin
                     if (sts.is_lf) cmd = put(cmd, KIND_PART_END, SRC_ZERO, 1'b0);
                     else           cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                  end
                  ST_BND_HY: begin
                     if (sts.is_hy) cmd = put(cmd, KIND_PART_END, SRC_ZERO, 1'b0);
                     else           cmd = put(cmd, KIND_ERROR, SRC_ZERO, 1'b1);
                  end
                  default: cmd.emit = 1'b0;
               endcase
            end
         end
         PH_PAIR: begin
            if (sts.out_free)
               cmd = put(cmd, (parse_state_ff == ST_EPILOGUE) ? KIND_BODY_END
                                                            : KIND_PART_BEGIN,
                         SRC_ZERO, 1'b1);
         end
         PH_FLUSH: begin
            if (sts.out_free) begin
               cmd            = put(cmd, KIND_DATA, SRC_SEQ,
                                    sts.flush_end && sts.hold_cr);
               cmd.flush_step = 1'b1;
            end
         end
         PH_TAIL: begin
            if (sts.out_free) cmd = put(cmd, KIND_DATA, SRC_HOLD, 1'b1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_state_ff <= ST_PREAMBLE;
         phase_ff       <= PH_RUN;
      end else begin
         parse_state_ff <= parse_state_in;
         phase_ff       <= phase_in;
      end
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (parse_state_ff == ST_HALT && !(accept && req_message_start))
      |=> parse_state_ff == ST_HALT)
      else $error("parser left halt without message start");

   a_pair_state: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAIR
      |-> (parse_state_ff == ST_HF_START || parse_state_ff == ST_EPILOGUE))
      else $error("event pair outside part/body boundary");

   a_flush_state: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FLUSH || phase_ff == PH_TAIL)
      |-> (parse_state_ff == ST_DATA || parse_state_ff == ST_D_CR))
      else $error("delimiter replay outside data section");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !cmd.last) |=> phase_ff != PH_RUN)
      else $error("non-final beat not followed by sequencer phase");

endmodule

### rtl/core/mbp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_dp
// Datapath: boundary registers and CSR port, boundary match index, byte
// classification, delimiter replay counter and the result output register.
// ----------------------------------------------------------------------------
module mbp_dp #(
   parameter int BOUNDARY_BYTES = mbp_pkg::DEF_BOUNDARY_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mbp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mbp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input  logic [mbp_pkg::BYTE_W-1:0]        req_in_byte,
   input  logic                              rsp_stall,
   input  mbp_pkg::cmd_type                  cmd,
   output mbp_pkg::status_type               sts,
   output logic                              rsp_valid,
   output mbp_pkg::kind_type                 rsp_kind,
   output logic [mbp_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_last
);
   import mbp_pkg::*;

   localparam int MI_W      = $clog2(BOUNDARY_BYTES + 2);
   localparam int FL_W      = $clog2(BOUNDARY_BYTES + 4);
   localparam int NUM_WORDS = (BOUNDARY_BYTES + 7) / 8;
   localparam int BI_W      = $clog2(NUM_WORDS * 8);

   logic [LEN_W-1:0]       length_ff;
   logic [CSR_DATA_W-1:0]  words_ff [NUM_WORDS];
   logic [NUM_WORDS*CSR_DATA_W-1:0] bnd_flat;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   csr_wr;

   logic [MI_W-1:0]        mi_ff, mi_in;
   logic [MI_W-1:0]        blen, m_eff;
   logic                   mi_lt_len;
   logic [BYTE_W-1:0]      hold_ff;
   logic [FL_W-1:0]        flen_ff, fidx_ff, fidx_back;
   logic [BI_W-1:0]        rd_idx;
   logic [BYTE_W-1:0]      bnd_rd, seq_byte, out_byte_in;

   logic                   rsp_valid_ff;
   kind_type               kind_ff;
   logic [BYTE_W-1:0]      out_byte_ff;
   logic                   last_ff;

   // ---------------- configuration port
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(1);
      end else if (csr_wr && reg_idx == REG_LENGTH) begin
         length_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
      always_ff @(posedge clock) begin
         if (reset) begin
            words_ff[w] <= '0;
         end else if (csr_wr && reg_idx == REG_IDX_W'(w) + REG_BND_FIRST) begin
            words_ff[w] <= csr_pwdata;
         end
      end
      assign bnd_flat[w*CSR_DATA_W +: CSR_DATA_W] = words_ff[w];
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_LENGTH) csr_prdata = CSR_DATA_W'(length_ff);
      for (int w = 0; w < NUM_WORDS; w++) begin
         if (reg_idx == REG_IDX_W'(w) + REG_BND_FIRST) csr_prdata = words_ff[w];
      end
   end

   // ---------------- boundary match
   always_comb begin
      if (length_ff == '0)
         blen = MI_W'(1);
      else if (length_ff > LEN_W'(BOUNDARY_BYTES))
         blen = MI_W'(BOUNDARY_BYTES);
      else
         blen = MI_W'(length_ff);
   end

   assign mi_lt_len = mi_ff < blen;
   assign m_eff     = mi_lt_len ? mi_ff : blen;
   assign fidx_back = fidx_ff - FL_W'(4);
   // replay reads boundary byte (position - 4); otherwise the compare slot
   assign rd_idx    = cmd.flush_rd ? fidx_back[BI_W-1:0] : mi_ff[BI_W-1:0];
   assign bnd_rd    = bnd_flat[{rd_idx, 3'b000} +: BYTE_W];
   assign seq_byte  = (fidx_ff < FL_W'(4)) ? seq_prefix(fidx_ff[1:0]) : bnd_rd;

   always_comb begin
      unique case (cmd.mi_op)
         MI_CLEAR: mi_in = '0;
         MI_INC:   mi_in = mi_ff + MI_W'(1);
         default:  mi_in = mi_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mi_ff <= '0;
      end else begin
         mi_ff <= mi_in;
      end
   end

   // replay bookkeeping; CR is beat 0 and goes out on the accepting cycle
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hold_ff <= req_in_byte;
         fidx_ff <= FL_W'(1);
         flen_ff <= (cmd.pfx == PFX_FULL) ? FL_W'(m_eff) + FL_W'(4) : FL_W'(cmd.pfx);
      end else if (cmd.flush_step) begin
         fidx_ff <= fidx_ff + FL_W'(1);
      end
   end

   // ---------------- status
   always_comb begin
      sts            = '0;
      sts.is_cr      = (req_in_byte == CH_CR);
      sts.is_lf      = (req_in_byte == CH_LF);
      sts.is_hy      = (req_in_byte == CH_HY);
      sts.is_sp      = (req_in_byte == CH_SP);
      sts.is_ht      = (req_in_byte == CH_HT);
      sts.is_colon   = (req_in_byte == CH_COLON);
      sts.is_token   = is_token(req_in_byte);
      sts.mi_eq_len  = (mi_ff == blen);
      sts.mi_eq_len1 = ({1'b0, mi_ff} == {1'b0, blen} + (MI_W+1)'(1));
      sts.bnd_match  = mi_lt_len && (req_in_byte == bnd_rd);
      sts.mi_last    = ({1'b0, mi_ff} + (MI_W+1)'(1) == {1'b0, blen});
      sts.flush_end  = (fidx_ff == flen_ff - FL_W'(1));
      sts.hold_cr    = (hold_ff == CH_CR);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // ---------------- output register
   always_comb begin
      unique case (cmd.src)
         SRC_REQ:  out_byte_in = req_in_byte;
         SRC_HOLD: out_byte_in = hold_ff;
         SRC_SEQ:  out_byte_in = seq_byte;
         SRC_CR:   out_byte_in = CH_CR;
         default:  out_byte_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff     <= cmd.kind;
         out_byte_ff <= out_byte_in;
         last_ff     <= cmd.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = last_ff;

endmodule

### rtl/core/multipart_body_parser.sv
`timescale 1ns / 1ps
// Output: the first result beat of a byte is registered on the cycle that accepts it.
// Throughput: one byte per cycle while each byte gives at most one beat and rsp_stall is
//   low; a byte with several beats stalls the input until its last beat is registered,
//   most on a failed match (CR LF - -, the matched boundary bytes, then the byte itself).
// Reset: synchronous, active high; parser returns to the preamble, boundary length 1.
// ----------------------------------------------------------------------------
// multipart_body_parser
// Streaming multipart body parser: finds boundaries, emits header name/value
// bytes, part data and framing events, one result beat per cycle unless rsp_stall holds it.
// ----------------------------------------------------------------------------
module multipart_body_parser #(
   parameter int BOUNDARY_BYTES = mbp_pkg::DEF_BOUNDARY_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mbp_pkg::BYTE_W-1:0]        req_in_byte,
   input  logic                              req_message_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mbp_pkg::kind_type                 rsp_kind,
   output logic [mbp_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mbp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mbp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import mbp_pkg::*;

   status_type sts;
   cmd_type    cmd;

   assign csr_pready = 1'b1;

   mbp_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_message_start (req_message_start),
      .req_stall         (req_stall),
      .sts               (sts),
      .cmd               (cmd)
   );

   mbp_dp #(
      .BOUNDARY_BYTES (BOUNDARY_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .req_in_byte  (req_in_byte),
      .rsp_stall    (rsp_stall),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

### tb/tb_multipart_body_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multipart_body_parser
// Streams multipart bodies through the parser one byte per beat. The input
// side and the result side both idle at random. Each accepted byte goes
// through a local model of the parse, which appends the events it predicts
// to a queue. Every result beat is checked against the head of that queue.
// The boundary registers are reprogrammed between phases while the parser
// is idle. Most bodies are well formed with random content; the rest are
// corrupted or plain noise.
// ----------------------------------------------------------------------------
module tb_multipart_body_parser;
   import mbp_pkg::*;

   localparam int unsigned BND_MAX      = DEF_BOUNDARY_BYTES;
   localparam int unsigned MAX_EVENTS   = 60;
   localparam int unsigned PHASE_BUDGET = 30;

   typedef struct {
      logic [7:0] data;
      logic       start;
   } byte_item_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } parse_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_in_byte = '0;
   logic                  req_message_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   kind_type              rsp_kind;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   multipart_body_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_message_start (req_message_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   // parser model state and its copy of the registers
   pstate_type    parser_state = ST_PREAMBLE;
   int unsigned   delim_idx = 0;
   logic [5:0]    cfg_len = 6'd1;
   logic [63:0]   bnd_word [7] = '{default: 64'h0};

   byte_item_type    byte_items [$];
   parse_result_type parse_events [$];
   parse_result_type step_out [$];
   logic          start_next = 1'b0;
   int unsigned   queued_count = 0;
   int unsigned   fail_count = 0;
   int unsigned   calm_left [2] = '{0, 0};
   int unsigned   req_idle = 0;
   int unsigned   rsp_idle = 0;

   task automatic report_mismatch(input string what);
      if (fail_count < 40) $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   // mostly back to back, some short gaps, a few long ones, and calm stretches
   function automatic int unsigned idle_len(input int side);
      int unsigned r;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         calm_left[side] = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic int unsigned eff_len();
      int unsigned l;
      l = 32'(cfg_len);
      if (l == 0) l = 1;
      if (l > BND_MAX) l = BND_MAX;
      return l;
   endfunction

   function automatic logic [7:0] bnd_byte(input int unsigned i);
      if (i >= BND_MAX) return 8'h00;
      return bnd_word[i / 8][(i % 8) * 8 +: 8];
   endfunction

   // letters, digits and the punctuation allowed in a header name
   function automatic logic name_char(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                       8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                       8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E};
   endfunction

   task automatic emit_event(input kind_type k, input logic [7:0] b);
      parse_result_type r;
      if (step_out.size() < MAX_EVENTS) begin
         r.kind = k;
         r.data = b;
         r.last = 1'b0;
         step_out.push_back(r);
      end
   endtask

   task automatic halt_parser();
      emit_event(KIND_ERROR, 8'h00);
      parser_state = ST_HALT;
   endtask

   task automatic data_byte(input logic [7:0] c);
      parser_state = ST_DATA;
      if (c == CH_CR) parser_state = ST_D_CR;
      else emit_event(KIND_DATA, c);
   endtask

   task automatic name_byte(input logic [7:0] c);
      parser_state = ST_HF;
      if (name_char(c)) emit_event(KIND_NAME, c);
      else if (c == CH_COLON) parser_state = ST_HV_START;
      else if (c == CH_CR) parser_state = ST_HV_CR;
      else halt_parser();
   endtask

   task automatic value_byte(input logic [7:0] c);
      parser_state = ST_HV;
      if (c == CH_CR) parser_state = ST_HV_CR;
      else emit_event(KIND_VALUE, c);
   endtask

   // one accepted byte: advance the model and queue the events it gives
   task automatic parse_byte(input logic [7:0] c, input logic restart);
      int unsigned len;
      int unsigned i;
      step_out.delete();
      len = eff_len();
      if (restart) begin
         parser_state = ST_PREAMBLE;
         delim_idx = 0;
      end
      case (parser_state)
         ST_PREAMBLE: begin
            if (c == CH_HY) parser_state = ST_PRE_HY;
         end
         ST_PRE_HY: begin
            if (c == CH_HY) begin
               parser_state = ST_FIRST;
               delim_idx = 0;
            end else begin
               parser_state = ST_PREAMBLE;
            end
         end
         ST_FIRST: begin
            if (delim_idx == len) begin
               if (c == CH_CR) delim_idx++;
               else halt_parser();
            end else if (delim_idx == len + 1) begin
               if (c == CH_LF) begin
                  emit_event(KIND_BODY_BEGIN, 8'h00);
                  emit_event(KIND_PART_BEGIN, 8'h00);
                  delim_idx = 0;
                  parser_state = ST_HF_START;
               end else begin
                  halt_parser();
               end
            end else if (delim_idx < len && c == bnd_byte(delim_idx)) begin
               delim_idx++;
            end else begin
               halt_parser();
            end
         end
         ST_HF_START: begin
            if (c == CH_CR) parser_state = ST_HDONE;
            else name_byte(c);
         end
         ST_HF: name_byte(c);
         ST_HV_START: begin
            if (c != CH_SP && c != CH_HT) value_byte(c);
         end
         ST_HV: value_byte(c);
         ST_HV_CR: begin
            if (c == CH_LF) parser_state = ST_HF_START;
            else halt_parser();
         end
         ST_HDONE: begin
            if (c == CH_LF) begin
               emit_event(KIND_HDRS_DONE, 8'h00);
               parser_state = ST_DATA;
            end else begin
               halt_parser();
            end
         end
         ST_DATA: data_byte(c);
         ST_D_CR: begin
            if (c == CH_LF) begin
               parser_state = ST_D_CRLF;
            end else begin
               emit_event(KIND_DATA, CH_CR);
               data_byte(c);
            end
         end
         ST_D_CRLF: begin
            if (c == CH_HY) begin
               parser_state = ST_D_CRLF_HY;
            end else begin
               emit_event(KIND_DATA, CH_CR);
               emit_event(KIND_DATA, CH_LF);
               data_byte(c);
            end
         end
         ST_D_CRLF_HY: begin
            if (c == CH_HY) begin
               parser_state = ST_D_BND;
               delim_idx = 0;
            end else begin
               emit_event(KIND_DATA, CH_CR);
               emit_event(KIND_DATA, CH_LF);
               emit_event(KIND_DATA, CH_HY);
               data_byte(c);
            end
         end
         ST_D_BND: begin
            if (delim_idx < len && c == bnd_byte(delim_idx)) begin
               delim_idx++;
               if (delim_idx == len) begin
                  delim_idx = 0;
                  parser_state = ST_BND_DONE;
               end
            end else begin
               // replay the withheld delimiter head, then take c fresh
               emit_event(KIND_DATA, CH_CR);
               emit_event(KIND_DATA, CH_LF);
               emit_event(KIND_DATA, CH_HY);
               emit_event(KIND_DATA, CH_HY);
               for (i = 0; i < delim_idx && i < len; i++) emit_event(KIND_DATA, bnd_byte(i));
               delim_idx = 0;
               data_byte(c);
            end
         end
         ST_BND_DONE: begin
            if (c == CH_CR) parser_state = ST_BND_CR;
            else if (c == CH_HY) parser_state = ST_BND_HY;
            else halt_parser();
         end
         ST_BND_CR: begin
            if (c == CH_LF) begin
               emit_event(KIND_PART_END, 8'h00);
               emit_event(KIND_PART_BEGIN, 8'h00);
               parser_state = ST_HF_START;
            end else begin
               halt_parser();
            end
         end
         ST_BND_HY: begin
            if (c == CH_HY) begin
               emit_event(KIND_PART_END, 8'h00);
               emit_event(KIND_BODY_END, 8'h00);
               parser_state = ST_EPILOGUE;
            end else begin
               halt_parser();
            end
         end
         ST_EPILOGUE: ;
         default: parser_state = ST_HALT;
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[k]) parse_events.push_back(step_out[k]);
   endtask

   // input side
   always @(posedge clock) begin
      byte_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         req_idle = 0;
      end else begin
         if (req_valid && !req_stall) parse_byte(req_in_byte, req_message_start);
         if (!req_valid || !req_stall) begin
            if (req_idle > 0) begin
               req_idle--;
               req_valid <= 1'b0;
            end else if (byte_items.size() > 0) begin
               it = byte_items.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= it.data;
               req_message_start <= it.start;
               req_idle = idle_len(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_idle = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parse_events.size() == 0) begin
               report_mismatch($sformatf("unexpected beat: kind %0d byte %02h last %0b",
                                         rsp_kind, rsp_out_byte, rsp_last));
            end else begin
               want = parse_events.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
               if (rsp_out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %02h, want %02h (kind %0d)",
                                            rsp_out_byte, want.data, want.kind));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, want %0b (kind %0d)",
                                            rsp_last, want.last, want.kind));
            end
         end
         if (rsp_idle > 0) begin
            rsp_idle--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_idle = idle_len(1);
         end
      end
   end

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_LENGTH) cfg_len = val[5:0];
      else bnd_word[idx - REG_BND_FIRST] = val;
   endtask

   task automatic queue_byte(input logic [7:0] b);
      byte_item_type it;
      it.data = b;
      it.start = start_next;
      start_next = 1'b0;
      byte_items.push_back(it);
      queued_count++;
   endtask

   function automatic logic [7:0] rand_byte_except(input logic [7:0] x);
      logic [7:0] b;
      do b = 8'($urandom); while (b == x);
      return b;
   endfunction

   task automatic queue_delimiter();
      int unsigned j;
      queue_byte(CH_HY);
      queue_byte(CH_HY);
      for (j = 0; j < eff_len(); j++) queue_byte(bnd_byte(j));
   endtask

   // one body: mostly well formed, sometimes with a byte hit, sometimes noise
   task automatic gen_message();
      string       name_set;
      int unsigned len, first, n, k, j, p, parts, h, style;
      name_set = "abczAZ09!#$%&'*+-.^_`|~";
      len = eff_len();
      first = byte_items.size();
      start_next = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(3, 12)) queue_byte(8'($urandom));
         return;
      end
      repeat ($urandom_range(0, 3)) queue_byte(rand_byte_except(CH_HY));
      if ($urandom_range(0, 3) == 0) begin
         queue_byte(CH_HY);
         queue_byte(rand_byte_except(CH_HY));
      end
      queue_delimiter();
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      // long boundaries make every delimiter costly: keep those bodies to one part
      parts = (len > 16) ? 1 : $urandom_range(1, 2);
      for (p = 0; p < parts; p++) begin
         for (h = $urandom_range(0, 2); h > 0; h--) begin
            style = $urandom_range(0, 5);
            if (style != 0)
               repeat ($urandom_range(1, 5))
                  queue_byte(name_set[$urandom_range(0, name_set.len() - 1)]);
            if (style == 1) begin
               queue_byte(CH_CR);
               queue_byte(CH_LF);
            end else begin
               queue_byte(CH_COLON);
               repeat ($urandom_range(0, 2)) queue_byte($urandom_range(0, 1) ? CH_SP : CH_HT);
               repeat ($urandom_range(0, 6)) queue_byte(rand_byte_except(CH_CR));
               queue_byte(CH_CR);
               queue_byte(CH_LF);
            end
         end
         queue_byte(CH_CR);
         queue_byte(CH_LF);
         for (n = $urandom_range(0, 8); n > 0; n--) begin
            case ($urandom_range(0, 9))
               0: queue_byte(CH_CR);
               1: begin
                  queue_byte(CH_CR);
                  queue_byte(CH_LF);
               end
               2: begin
                  queue_byte(CH_CR);
                  queue_byte(CH_LF);
                  queue_byte(CH_HY);
               end
               3: begin
                  // delimiter that breaks off partway into the boundary
                  k = (len > 4 && $urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                             : $urandom_range(0, len - 1);
                  queue_byte(CH_CR);
                  queue_byte(CH_LF);
                  queue_byte(CH_HY);
                  queue_byte(CH_HY);
                  for (j = 0; j < k; j++) queue_byte(bnd_byte(j));
                  queue_byte(8'($urandom));
               end
               default: queue_byte(8'($urandom));
            endcase
         end
         queue_byte(CH_CR);
         queue_byte(CH_LF);
         queue_delimiter();
         if (p == parts - 1) begin
            queue_byte(CH_HY);
            queue_byte(CH_HY);
         end else begin
            queue_byte(CH_CR);
            queue_byte(CH_LF);
         end
      end
      repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
      if ($urandom_range(0, 3) == 0)
         byte_items[$urandom_range(first + 1, byte_items.size() - 1)].data = 8'($urandom);
   endtask

   task automatic wait_quiet();
      while (byte_items.size() != 0 || req_valid || parse_events.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int unsigned phase_len [4];
      int unsigned p, r, mark;
      logic [63:0] w;
      // zero length, oversize length (clamps to the maximum), two short ones
      phase_len = '{0, 63, 5, 12};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset boundary: one zero byte
      start_next = 1'b1;
      queue_byte(CH_HY);
      queue_byte(8'h61);          // lone hyphen in preamble, ignored
      queue_byte(CH_HY);
      queue_byte(CH_HY);
      queue_byte(8'h00);
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      queue_byte(CH_COLON);       // header with empty name
      queue_byte(CH_HT);
      queue_byte(8'hFF);
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      queue_byte(8'h41);          // name ended by CR, no value
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      queue_byte(CH_HY);
      queue_byte(CH_HY);
      queue_byte(8'h00);
      queue_byte(CH_HY);
      queue_byte(CH_HY);
      start_next = 1'b1;
      queue_byte(CH_HY);
      queue_byte(CH_HY);
      queue_byte(8'h01);          // wrong boundary byte
      wait_quiet();

      for (p = 0; p < 4; p++) begin
         if (p == 2) phase_len[p] = $urandom_range(2, 8);
         if (p == 3) phase_len[p] = $urandom_range(1, 16);
         w = {$urandom, $urandom};
         csr_write(REG_LENGTH, (w & ~64'h3F) | 64'(phase_len[p]));
         for (r = 0; r < 7; r++) begin
            w = (p == 2) ? '1 : {$urandom, $urandom};
            csr_write(REG_BND_FIRST + REG_IDX_W'(r), w);
         end
         mark = queued_count;
         while (queued_count - mark < PHASE_BUDGET) gen_message();
         wait_quiet();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### files.f
rtl/core/mbp_pkg.sv
rtl/core/mbp_ctrl.sv
rtl/core/mbp_dp.sv
rtl/core/multipart_body_parser.sv
tb/tb_multipart_body_parser.sv
